// ----- design/per_cpu_page_free_list_allocator_assert.svh -----
// Assertion helpers for the page allocator.
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define PCPFL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("allocator check failed");

`define PCPFL_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("allocator forbidden condition");

`else

`define PCPFL_ASSERT(lbl, clk, rst_n, prop)

`define PCPFL_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- design/pcpfl_pkg.sv -----
package pcpfl_pkg;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic CFG_FREE_BASE = 1'b0;
    localparam logic CFG_FREE_TOP  = 1'b1;

    localparam logic [31:0] FREE_BASE_RST = 32'h8000_0000;
    localparam logic [31:0] FREE_TOP_RST  = 32'h8800_0000;

    typedef struct packed {
        logic        func;
        logic [2:0]  cpu;
        logic [31:0] addr;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [31:0] page_addr;
        logic        bad_free;
    } t_res;

    // shared add/subtract unit request
    typedef struct packed {
        logic [32:0] a;
        logic [32:0] b;
        logic        sub;
    } t_alu_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_LO,
        ST_HI,
        ST_OFFS,
        ST_PUSH,
        ST_READ,
        ST_POP
    } t_state;

endpackage

// ----- design/pcpfl_alu.sv -----
module pcpfl_alu (
    input  pcpfl_pkg::t_alu_req i_req,
    output logic [33:0]         o_sum
);
    import pcpfl_pkg::*;

    logic [33:0] a_ext;
    logic [33:0] b_ext;

    assign a_ext = {1'b0, i_req.a};
    assign b_ext = i_req.sub ? ~{1'b0, i_req.b} : {1'b0, i_req.b};

    // on subtract, bit 33 is set when a < b
    assign o_sum = a_ext + b_ext + {33'd0, i_req.sub};

endmodule

// ----- design/per_cpu_page_free_list_allocator.sv -----
// Per-CPU page free-list allocator with stealing.
// Command channel: drive i_req with start high while busy is low; the
// transaction is taken at that clock edge and busy rises the next cycle.
// func=free pushes the page at addr onto the list of cpu, after alignment
// and range checks against free_base/free_top (bad_free on failure).
// func=alloc pops the head of cpu's list, or of the lowest-numbered other
// non-empty list; ok=0 and page_addr=0 when every list is empty.
// Each transaction gives one result on o_res, valid for one cycle while
// o_done is high; the receiver cannot stall it.
// Timing: a free walks four add/compare steps (BASE, LO, HI, OFFS) on one
// shared adder plus a PUSH step; an alloc passes BASE, READ (the synchronous
// next-page memory read, needed before the head can move) and POP. Busy is
// high through these states and the result is registered out of PUSH or POP.
// The next start may be given in the cycle the result is shown.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data write free_base (0) or free_top (1)
// at once; write only while idle.
// Reset empties all lists and restores the register defaults; the
// next-page memory is not cleared, only entries written by frees are read.
module per_cpu_page_free_list_allocator #(
    parameter int NUM_CPUS  = 8,
    parameter int NUM_PAGES = 32768,
    parameter int PAGE_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  pcpfl_pkg::t_req   i_req,
    output logic              busy,
    output logic              o_done,
    output pcpfl_pkg::t_res   o_res,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);
    import pcpfl_pkg::*;

`include "per_cpu_page_free_list_allocator_assert.svh"

    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam logic [32:0] PMASK = (33'd1 << PAGE_BITS) - 33'd1;

    t_state r_state, n_state;

    logic [31:0] r_free_base;
    logic [31:0] r_free_top;

    t_req        r_req;
    logic [32:0] r_base, n_base;
    logic        r_bad, n_bad;
    logic [31:0] r_offs, n_offs;
    logic [CPU_W-1:0] r_sel, n_sel;
    logic [15:0] r_h, n_h;
    logic        r_found, n_found;

    logic [15:0] r_head [NUM_CPUS];
    logic [15:0] r_next_page [NUM_PAGES];
    logic [15:0] r_rd_data;

    logic        r_done, n_done;
    t_res        r_res, n_res;

    t_alu_req    alu_req;
    logic [33:0] alu_sum;

    logic             head_we;
    logic [CPU_W-1:0] head_sel;
    logic [15:0]      head_wdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [15:0]      mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    logic [31:0]      cpu_ext;
    logic             cpu_ok;
    logic [CPU_W-1:0] cpu_idx;
    logic [31:0]      offs_idx;
    logic [15:0]      h_m1;
    logic [CPU_W-1:0] pick;
    logic             pick_found;
    logic             accept;

    pcpfl_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    assign accept   = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_res    = r_res;

    assign cpu_ext  = 32'(r_req.cpu);
    assign cpu_ok   = cpu_ext < 32'(NUM_CPUS);
    assign cpu_idx  = cpu_ext[CPU_W-1:0];
    assign offs_idx = r_offs >> PAGE_BITS;
    assign h_m1     = r_h - 16'd1;
    assign mem_raddr = h_m1[IDX_W-1:0];

    // victim search: own list first, else lowest-numbered other non-empty
    always_comb begin
        pick       = '0;
        pick_found = 1'b0;
        for (int c = NUM_CPUS - 1; c >= 0; c--) begin
            if (r_head[c] != 16'd0 && 32'(c) != cpu_ext) begin
                pick       = CPU_W'(c);
                pick_found = 1'b1;
            end
        end
        if (cpu_ok && r_head[cpu_idx] != 16'd0) begin
            pick       = cpu_idx;
            pick_found = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_BASE;
            ST_BASE: n_state = (r_req.func == FUNC_FREE) ? ST_LO : ST_READ;
            ST_LO:   n_state = ST_HI;
            ST_HI:   n_state = ST_OFFS;
            ST_OFFS: n_state = ST_PUSH;
            ST_PUSH: n_state = ST_IDLE;
            ST_READ: n_state = ST_POP;
            ST_POP:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        alu_req    = '{a: 33'd0, b: 33'd0, sub: 1'b0};
        n_base     = r_base;
        n_bad      = r_bad;
        n_offs     = r_offs;
        n_sel      = r_sel;
        n_h        = r_h;
        n_found    = r_found;
        n_done     = 1'b0;
        n_res      = r_res;
        head_we    = 1'b0;
        head_sel   = r_sel;
        head_wdata = r_rd_data;
        mem_we     = 1'b0;
        mem_waddr  = offs_idx[IDX_W-1:0];
        mem_wdata  = r_head[cpu_idx];
        case (r_state)
            ST_IDLE: begin
                n_bad = 1'b0;
            end
            ST_BASE: begin
                alu_req = '{a: {1'b0, r_free_base}, b: PMASK, sub: 1'b0};
                n_base  = alu_sum[32:0] & ~PMASK;
                n_sel   = pick;
                n_found = pick_found;
                n_h     = r_head[pick];
                n_bad   = (r_req.addr[PAGE_BITS-1:0] != '0);
            end
            ST_LO: begin
                alu_req = '{a: {1'b0, r_req.addr}, b: {1'b0, r_free_base}, sub: 1'b1};
                if (alu_sum[33]) n_bad = 1'b1;
            end
            ST_HI: begin
                alu_req = '{a: {1'b0, r_req.addr}, b: {1'b0, r_free_top}, sub: 1'b1};
                if (!alu_sum[33]) n_bad = 1'b1;
            end
            ST_OFFS: begin
                alu_req = '{a: {1'b0, r_req.addr}, b: r_base, sub: 1'b1};
                n_offs  = alu_sum[31:0];
                if (alu_sum[33]) n_bad = 1'b1;
            end
            ST_PUSH: begin
                n_done = 1'b1;
                n_res  = '{ok: 1'b0, page_addr: 32'd0, bad_free: 1'b0};
                if (r_bad || offs_idx >= 32'(NUM_PAGES)) begin
                    n_res.bad_free = 1'b1;
                end else if (cpu_ok) begin
                    mem_we     = 1'b1;
                    head_we    = 1'b1;
                    head_sel   = cpu_idx;
                    head_wdata = offs_idx[15:0] + 16'd1;
                    n_res.ok   = 1'b1;
                end
            end
            ST_READ: begin
                // memory read of the head's link is in flight
            end
            ST_POP: begin
                alu_req = '{a: r_base, b: 33'(h_m1) << PAGE_BITS, sub: 1'b0};
                n_done  = 1'b1;
                n_res   = '{ok: r_found, page_addr: 32'd0, bad_free: 1'b0};
                if (r_found) begin
                    head_we         = 1'b1;
                    head_sel        = r_sel;
                    head_wdata      = r_rd_data;
                    n_res.page_addr = alu_sum[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_free_base <= FREE_BASE_RST;
            r_free_top  <= FREE_TOP_RST;
            r_done      <= 1'b0;
            r_bad       <= 1'b0;
            r_found     <= 1'b0;
            for (int c = 0; c < NUM_CPUS; c++) begin
                r_head[c] <= 16'd0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_bad   <= n_bad;
            r_found <= n_found;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FREE_BASE: r_free_base <= i_cfg_data;
                    CFG_FREE_TOP:  r_free_top  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (head_we) begin
                r_head[head_sel] <= head_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        r_base <= n_base;
        r_offs <= n_offs;
        r_sel  <= n_sel;
        r_h    <= n_h;
        r_res  <= n_res;
    end

    // next-page link memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_next_page[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_next_page[mem_raddr];
    end

    `PCPFL_ASSERT(a_done_after_final, i_clk, i_rst_n,
                  o_done |-> ($past(r_state) == ST_PUSH || $past(r_state) == ST_POP))
    `PCPFL_ASSERT(a_accept_starts, i_clk, i_rst_n, accept |=> r_state == ST_BASE)
    `PCPFL_NEVER(a_bad_and_ok, i_clk, i_rst_n, o_done && o_res.bad_free && o_res.ok)
    `PCPFL_ASSERT(a_fail_zero_addr, i_clk, i_rst_n,
                  (o_done && !o_res.ok) |-> o_res.page_addr == 32'd0)

endmodule

// ----- sim/page_list_checker.sv -----
`timescale 1ns / 1ps

module page_list_checker #(
    parameter int NUM_CPUS  = 8,
    parameter int NUM_PAGES = 32768,
    parameter int PAGE_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  pcpfl_pkg::t_req   i_req,
    input  logic              i_done,
    input  pcpfl_pkg::t_res   i_res,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_grants,
    output int                o_steals,
    output int                o_empty_allocs,
    output int                o_refused_frees
);
    import pcpfl_pkg::*;

    logic [31:0] base_reg;
    logic [31:0] top_reg;
    // list heads and links hold 1 + page index, 0 marks an empty list / end
    logic [15:0] head_q [NUM_CPUS];
    logic [15:0] next_pg [NUM_PAGES];
    t_res        expected_results [$];

    initial begin
        o_errors        = 0;
        o_pending       = 0;
        o_grants        = 0;
        o_steals        = 0;
        o_empty_allocs  = 0;
        o_refused_frees = 0;
        base_reg        = FREE_BASE_RST;
        top_reg         = FREE_TOP_RST;
        for (int i = 0; i < NUM_CPUS; i++) head_q[i] = '0;
        for (int i = 0; i < NUM_PAGES; i++) next_pg[i] = '0;
    end

    function automatic logic [15:0] pop_head(int c);
        logic [15:0] h;
        logic [31:0] i;
        h = head_q[c];
        if (h != 16'd0) begin
            i = 32'(h) - 32'd1;
            head_q[c] = (i < NUM_PAGES) ? next_pg[i] : 16'd0;
        end
        return h;
    endfunction

    function automatic t_res predict_page_op(t_req r);
        logic [63:0] pmask;
        logic [63:0] base;
        logic [63:0] addr;
        logic [63:0] idx;
        logic [63:0] pa;
        logic [15:0] h;
        int          c;
        t_res        res;
        pmask = (64'd1 << PAGE_BITS) - 64'd1;
        base  = ({32'd0, base_reg} + pmask) & ~pmask;
        addr  = {32'd0, r.addr};
        res   = '0;
        if (r.func == FUNC_FREE) begin
            if ((addr & pmask) != 64'd0 || addr < {32'd0, base_reg} ||
                addr >= {32'd0, top_reg} || addr < base ||
                ((addr - base) >> PAGE_BITS) >= 64'(NUM_PAGES)) begin
                res.bad_free = 1'b1;
                o_refused_frees++;
            end else if (r.cpu < NUM_CPUS) begin
                idx = (addr - base) >> PAGE_BITS;
                next_pg[idx] = head_q[r.cpu];
                head_q[r.cpu] = idx[15:0] + 16'd1;
                res.ok = 1'b1;
            end
        end else begin
            h = 16'd0;
            if (r.cpu < NUM_CPUS) h = pop_head(int'(r.cpu));
            // own list empty: take from the lowest-numbered other list
            for (c = 0; c < NUM_CPUS && h == 16'd0; c++) begin
                if (c != int'(r.cpu)) begin
                    h = pop_head(c);
                    if (h != 16'd0) o_steals++;
                end
            end
            if (h != 16'd0) begin
                pa = base + (64'(h - 16'd1) << PAGE_BITS);
                res.ok = 1'b1;
                res.page_addr = pa[31:0];
                o_grants++;
            end else begin
                o_empty_allocs++;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            base_reg = FREE_BASE_RST;
            top_reg  = FREE_TOP_RST;
            for (int i = 0; i < NUM_CPUS; i++) head_q[i] = '0;
            expected_results.delete();
        end else begin
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result ok=%0b page_addr=%h bad_free=%0b",
                             $time, i_res.ok, i_res.page_addr, i_res.bad_free);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res !== want) begin
                        $display("%0t: mismatch expected ok=%0b page_addr=%h bad_free=%0b",
                                 $time, want.ok, want.page_addr, want.bad_free);
                        $display("%0t:          actual   ok=%0b page_addr=%h bad_free=%0b",
                                 $time, i_res.ok, i_res.page_addr, i_res.bad_free);
                        o_errors++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FREE_BASE) base_reg = i_cfg_data;
                else top_reg = i_cfg_data;
            end
            if (i_start && !i_busy) expected_results.push_back(predict_page_op(i_req));
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import pcpfl_pkg::*;

    localparam int NCPU  = 8;
    localparam int NPAGE = 32768;
    localparam int PBITS = 12;

    logic        clk;
    logic        rst_n;
    logic        start;
    t_req        req;
    logic        busy;
    logic        done;
    t_res        res;
    logic        cfg_we;
    logic        cfg_idx;
    logic [31:0] cfg_data;

    int errors;
    int pending;
    int grants;
    int steals;
    int empty_allocs;
    int refused_frees;

    // stimulus-side view of the limits, used only to aim free addresses
    logic [31:0] cur_base;
    logic [31:0] cur_top;
    int          page_ctr;
    int          top_ctr;
    int          calm;
    int          settings;
    int          sent;
    logic        allow_dup;
    logic        have_last;
    logic [31:0] last_good;

    per_cpu_page_free_list_allocator #(
        .NUM_CPUS  (NCPU),
        .NUM_PAGES (NPAGE),
        .PAGE_BITS (PBITS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .i_req      (req),
        .busy       (busy),
        .o_done     (done),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    page_list_checker #(
        .NUM_CPUS  (NCPU),
        .NUM_PAGES (NPAGE),
        .PAGE_BITS (PBITS)
    ) i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_req           (req),
        .i_done          (done),
        .i_res           (res),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_grants        (grants),
        .o_steals        (steals),
        .o_empty_allocs  (empty_allocs),
        .o_refused_frees (refused_frees)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) calm = $urandom_range(10, 30);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    // Mostly fresh pages inside the current window, so lists are not linked
    // twice; the rest is misaligned, just outside the limits, or noise.
    function automatic logic [31:0] pick_free_addr();
        logic [63:0] pmask;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] npages;
        logic [63:0] a;
        int          r;
        pmask = (64'd1 << PBITS) - 64'd1;
        lo = ({32'd0, cur_base} + pmask) & ~pmask;
        hi = {32'd0, cur_top};
        if (hi > lo + (64'(NPAGE) << PBITS)) hi = lo + (64'(NPAGE) << PBITS);
        npages = (hi > lo) ? ((hi - lo + pmask) >> PBITS) : 64'd0;
        r = $urandom_range(0, 99);
        if (npages != 0 && r < 72) begin
            if (allow_dup && have_last && $urandom_range(0, 9) == 0) return last_good;
            if ($urandom_range(0, 19) == 0) begin
                a = lo + ((npages - 1 - (64'(top_ctr) % npages)) << PBITS);
                top_ctr++;
            end else begin
                a = lo + ((64'(page_ctr) % npages) << PBITS);
                page_ctr++;
            end
            last_good = a[31:0];
            have_last = 1'b1;
        end else if (r < 80) begin
            a = lo + (64'($urandom_range(0, 63)) << PBITS)
                + 64'($urandom_range(1, int'(pmask)));
        end else if (r < 90) begin
            case ($urandom_range(0, 2))
                0: a = lo - (pmask + 64'd1);
                1: a = lo + (64'(NPAGE) << PBITS);
                default: a = {32'd0, cur_top};
            endcase
        end else begin
            a = {32'd0, $urandom()};
        end
        return a[31:0];
    endfunction

    // entered and left just after a falling edge; start stays high on exit
    task automatic issue(logic func, logic [2:0] cpu, logic [31:0] addr, int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    = 1'b1;
        req.func = func;
        req.cpu  = cpu;
        req.addr = addr;
        do @(posedge clk); while (busy);
        sent++;
        @(negedge clk);
    endtask

    task automatic set_limits(logic [31:0] base, logic [31:0] top);
        start = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = CFG_FREE_BASE;
        cfg_data = base;
        @(negedge clk);
        cfg_idx  = CFG_FREE_TOP;
        cfg_data = top;
        @(negedge clk);
        cfg_we   = 1'b0;
        cur_base = base;
        cur_top  = top;
        have_last = 1'b0;
        settings++;
    endtask

    task automatic random_phase(int n, int free_pct);
        logic        is_free;
        logic [31:0] addr;
        for (int k = 0; k < n; k++) begin
            is_free = ($urandom_range(0, 99) < free_pct);
            addr = is_free ? pick_free_addr() : $urandom();
            issue(is_free ? FUNC_FREE : FUNC_ALLOC, 3'($urandom_range(0, 7)), addr,
                  pick_gap());
        end
    endtask

    initial begin
        int waited;
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_FREE_BASE;
        cfg_data  = '0;
        cur_base  = FREE_BASE_RST;
        cur_top   = FREE_TOP_RST;
        page_ctr  = 16;
        top_ctr   = 1;
        calm      = 0;
        settings  = 1;
        sent      = 0;
        allow_dup = 1'b0;
        have_last = 1'b0;
        last_good = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset limits: empty lists, range edges, LIFO order, stealing
        issue(FUNC_ALLOC, 3'd0, 32'h0000_0000, 0);
        issue(FUNC_FREE,  3'd0, 32'h8000_0000, 0);
        issue(FUNC_FREE,  3'd7, 32'h87FF_F000, 0);
        issue(FUNC_FREE,  3'd1, 32'h8000_1001, 0);
        issue(FUNC_FREE,  3'd1, 32'h7FFF_F000, 0);
        issue(FUNC_FREE,  3'd2, 32'h8800_0000, 0);
        issue(FUNC_FREE,  3'd6, 32'hFFFF_FFFF, 0);
        issue(FUNC_FREE,  3'd5, 32'h0000_0000, 0);
        issue(FUNC_FREE,  3'd0, 32'h8000_5000, 0);
        issue(FUNC_ALLOC, 3'd0, 32'h0000_0000, 0);
        issue(FUNC_ALLOC, 3'd0, 32'h0000_0000, 0);
        issue(FUNC_ALLOC, 3'd3, 32'h0000_0000, 0);
        issue(FUNC_ALLOC, 3'd7, 32'h0000_0000, 0);
        issue(FUNC_FREE,  3'd4, 32'h8000_3000, 0);
        issue(FUNC_FREE,  3'd6, 32'h8000_4000, 0);
        issue(FUNC_ALLOC, 3'd1, 32'h0000_0000, 0);
        issue(FUNC_ALLOC, 3'd7, 32'h0000_0000, 0);
        issue(FUNC_ALLOC, 3'd2, 32'hFFFF_FFFF, 0);
        random_phase(170, 55);

        // widest limits: only the page count bounds the index
        set_limits(32'h0000_0000, 32'hFFFF_FFFF);
        issue(FUNC_FREE,  3'd5, 32'h07FF_F000, 0);
        issue(FUNC_FREE,  3'd5, 32'h0800_0000, 0);
        issue(FUNC_ALLOC, 3'd5, 32'h0000_0000, 0);
        random_phase(190, 55);

        // unaligned base rounds up; small window
        set_limits(32'h0000_1234, 32'h0040_0000);
        random_phase(190, 55);

        // base in the last partial page: every aligned free is refused,
        // listed pages come back at wrapped addresses
        set_limits(32'hFFFF_F001, 32'hFFFF_FFFF);
        issue(FUNC_FREE,  3'd0, 32'hFFFF_F000, 0);
        issue(FUNC_ALLOC, 3'd0, 32'h0000_0000, 0);
        random_phase(150, 50);

        set_limits(32'hFFFF_0000, 32'h0000_0000);
        random_phase(100, 50);

        // double frees link a page twice; lists may then repeat pages
        set_limits(32'h4000_0000, 32'h4010_0000);
        issue(FUNC_FREE,  3'd2, 32'h4000_2000, 0);
        issue(FUNC_FREE,  3'd2, 32'h4000_2000, 0);
        issue(FUNC_ALLOC, 3'd2, 32'h0000_0000, 0);
        issue(FUNC_ALLOC, 3'd2, 32'h0000_0000, 0);
        allow_dup = 1'b1;
        random_phase(150, 55);

        set_limits(FREE_BASE_RST, FREE_TOP_RST);
        random_phase(200, 55);

        start = 1'b0;
        waited = 0;
        while (pending != 0 && waited < 2000) begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);

        $display("Ran %0d transactions over %0d limit settings; %0d refused frees",
                 sent, settings, refused_frees);
        $display("Allocs: %0d granted (%0d from another CPU list), %0d found all lists empty",
                 grants, steals, empty_allocs);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
